[hdl/fsr_pkg.sv]
package fsr_pkg;

   // Frame limits. The length byte counts the whole frame.
   localparam logic [7:0] FRAME_MAX = 8'd11;
   localparam logic [7:0] MIN_LEN   = 8'd7;
   localparam logic [3:0] CMD_POS   = 4'd5;

   // Reception phases.
   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_LEN  = 2'd1;
   localparam logic [1:0] PH_ADDR = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_OK        = 3'd1;
   localparam logic [2:0] ST_BAD_SUM   = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR  = 3'd3;
   localparam logic [2:0] ST_BAD_LEN   = 3'd4;
   localparam logic [2:0] ST_LOCKED    = 3'd5;

   // Transaction function codes.
   localparam logic FN_BYTE    = 1'b0;
   localparam logic FN_RELEASE = 1'b1;

   // Configuration registers.
   localparam int unsigned  CSR_INDEX_W     = 1;
   localparam logic [0:0]   REG_START_BYTE  = 1'b0;
   localparam logic [0:0]   REG_OWN_ADDRESS = 1'b1;
   localparam logic [7:0]   START_BYTE_RST  = 8'hFE;
   localparam logic [7:0]   OWN_ADDRESS_RST = 8'h02;

   typedef struct packed {
      logic [1:0] phase;
      logic [3:0] frame_length;
      logic [3:0] byte_position;
      logic [7:0] running_sum;
      logic [7:0] command_byte;
      logic       locked;
   } frame_state_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] command;
   } result_type;

endpackage

[hdl/fsr_req_if.sv]
interface fsr_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] rx_byte;

   modport source (output valid, output func, output rx_byte, input ready);
   modport sink (input valid, input func, input rx_byte, output ready);
endinterface

[hdl/fsr_rsp_if.sv]
interface fsr_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] command;

   modport source (output valid, output status, output command, input ready);
   modport sink (input valid, input status, input command, output ready);
endinterface

[hdl/fsr_parser.sv]
// Next-state and result logic for one received transaction.
module fsr_parser (
   input  fsr_pkg::frame_state_type cur,
   input  logic                     func,
   input  logic [7:0]               rx_byte,
   input  logic [7:0]               start_byte,
   input  logic [7:0]               own_address,
   output fsr_pkg::frame_state_type nxt,
   output fsr_pkg::result_type      result
);

   fsr_pkg::frame_state_type cleared;
   logic [7:0]               sum_plus;
   logic                     last_byte;

   assign sum_plus  = cur.running_sum + rx_byte;
   assign last_byte = ({1'b0, cur.byte_position} + 5'd1) >= {1'b0, cur.frame_length};

   always_comb begin
      cleared               = cur;
      cleared.phase         = fsr_pkg::PH_HUNT;
      cleared.frame_length  = 4'd0;
      cleared.byte_position = 4'd0;
      cleared.running_sum   = 8'd0;
      cleared.command_byte  = 8'd0;
   end

   always_comb begin
      nxt            = cur;
      result.status  = fsr_pkg::ST_IDLE;
      result.command = 8'd0;
      if (func == fsr_pkg::FN_RELEASE) begin
         nxt        = cleared;
         nxt.locked = 1'b0;
      end else if (cur.locked) begin
         result.status = fsr_pkg::ST_LOCKED;
      end else begin
         unique case (cur.phase)
            fsr_pkg::PH_HUNT: begin
               if (rx_byte == start_byte) begin
                  nxt.running_sum   = rx_byte;
                  nxt.byte_position = 4'd1;
                  nxt.phase         = fsr_pkg::PH_LEN;
               end
            end
            fsr_pkg::PH_LEN: begin
               if (rx_byte < fsr_pkg::MIN_LEN || rx_byte > fsr_pkg::FRAME_MAX) begin
                  result.status = fsr_pkg::ST_BAD_LEN;
                  nxt           = cleared;
               end else begin
                  nxt.frame_length  = rx_byte[3:0];
                  nxt.running_sum   = sum_plus;
                  nxt.byte_position = 4'd2;
                  nxt.phase         = fsr_pkg::PH_ADDR;
               end
            end
            fsr_pkg::PH_ADDR: begin
               if (rx_byte != own_address) begin
                  result.status = fsr_pkg::ST_BAD_ADDR;
                  nxt           = cleared;
               end else begin
                  nxt.running_sum   = sum_plus;
                  nxt.byte_position = 4'd3;
                  nxt.phase         = fsr_pkg::PH_DATA;
               end
            end
            default: begin
               if (last_byte) begin
                  if (cur.running_sum == rx_byte) begin
                     result.status  = fsr_pkg::ST_OK;
                     result.command = cur.command_byte;
                     nxt            = cleared;
                     nxt.locked     = 1'b1;
                  end else begin
                     result.status = fsr_pkg::ST_BAD_SUM;
                     nxt           = cleared;
                  end
               end else begin
                  if (cur.byte_position == fsr_pkg::CMD_POS) begin
                     nxt.command_byte = rx_byte;
                  end
                  nxt.running_sum   = sum_plus;
                  nxt.byte_position = cur.byte_position + 4'd1;
               end
            end
         endcase
      end
   end

endmodule

[hdl/framed_serial_receiver.sv]
// Framed serial receiver.
// Each request transaction carries either one received byte (func 0) or a
// release marker (func 1) that says the reply has been sent. The receiver hunts
// for the start byte, then checks the length byte, the address byte and finally
// the check byte, which must equal the sum modulo 256 of all bytes before it.
// A good frame answers status 1 with its command byte and locks the receiver;
// bytes that arrive while it is locked are answered with status 5 until a
// release transaction comes in.
// Every request transaction yields exactly one response transaction, registered
// in the cycle after it is accepted. One transaction is taken per cycle unless
// responses stall: the whole update is a single pass through the parser logic
// into the state and response registers. A held response blocks new requests,
// and reception resumes in the same cycle that the response is taken.
// Reset is synchronous: it empties the response register, returns the receiver
// to hunting, unlocks it, restores start byte FE and own address 02. The csr_
// port writes both registers; users must use it only while idle (not enforced).
module framed_serial_receiver (
   input  logic                               clock,
   input  logic                               reset,
   fsr_req_if.sink                            req_ch,
   fsr_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [fsr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [7:0]                         csr_wdata
);

   fsr_pkg::frame_state_type state_ff, state_in;
   fsr_pkg::result_type      result_ff, result_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               start_byte_ff, own_address_ff;
   logic                     req_take;

   // A new request is taken whenever the response register is empty or is
   // being emptied in this very cycle.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   fsr_parser u_parser (
      .cur         (state_ff),
      .func        (req_ch.func),
      .rx_byte     (req_ch.rx_byte),
      .start_byte  (start_byte_ff),
      .own_address (own_address_ff),
      .nxt         (state_in),
      .result      (result_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Frame state advances only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= fsr_pkg::PH_HUNT;
         state_ff.frame_length  <= 4'd0;
         state_ff.byte_position <= 4'd0;
         state_ff.running_sum   <= 8'd0;
         state_ff.command_byte  <= 8'd0;
         state_ff.locked        <= 1'b0;
         rsp_valid_ff           <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // The response payload needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= fsr_pkg::START_BYTE_RST;
         own_address_ff <= fsr_pkg::OWN_ADDRESS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            fsr_pkg::REG_START_BYTE:  start_byte_ff  <= csr_wdata;
            fsr_pkg::REG_OWN_ADDRESS: own_address_ff <= csr_wdata;
         endcase
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = result_ff.status;
   assign rsp_ch.command = result_ff.command;

   // An accepted request always produces a response in the next cycle.
   a_take_gives_response: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   // A frame-ok response leaves the receiver locked.
   a_ok_locks: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status == fsr_pkg::ST_OK) |-> state_ff.locked)
      else $error("frame accepted but receiver not locked");

   // A byte is only ignored as locked while the lock is held.
   a_locked_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status == fsr_pkg::ST_LOCKED) |-> state_ff.locked)
      else $error("locked status reported while unlocked");

   // The command byte is only reported with a good frame.
   a_command_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status != fsr_pkg::ST_OK) |-> result_ff.command == 8'd0)
      else $error("command byte reported without a good frame");

endmodule

[tb/tb_framed_serial_receiver.sv]
`timescale 1ns / 100ps

// Self-checking bench for the framed serial receiver.
//
// The stimulus is a stream of request transactions, each a received byte or a
// release marker. A main initial block queues them up in phases, one phase per
// pair of register settings. A clocked driver plays the queue onto the request
// channel with random gaps between transactions. Whenever a request transaction
// is accepted, the driver runs it through a local copy of the frame parser and
// queues up the response that the receiver ought to give. A clocked monitor
// stalls the response channel at random and compares every accepted response,
// field by field, with the oldest queued response. A watchdog ends the run if
// nothing moves on either channel for too long.
module tb_framed_serial_receiver;
   import fsr_pkg::*;

   // Cycles with no transaction on either channel before the run is declared
   // hung. The limit leaves a wide margin over the longest gap on either side,
   // as each response is valid in the cycle after its request is accepted.
   localparam int unsigned STALL_LIMIT = 1000;
   // Request transactions per register setting. There are five settings.
   localparam int unsigned PHASE_ITEMS = 370;

   typedef struct packed {
      logic       func;
      logic [7:0] rx_byte;
   } stream_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   fsr_req_if req_bus ();
   fsr_rsp_if rsp_bus ();

   framed_serial_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Transactions still to be sent, and the responses that they ought to raise.
   stream_item_type byte_stream[$];
   result_type      expected_replies[$];

   // Bench copy of the receiver's registers and its parser state.
   logic [7:0]      cfg_start;
   logic [7:0]      cfg_address;
   frame_state_type parser;

   int unsigned items_queued = 0;
   int unsigned results_seen = 0;
   int unsigned errors = 0;
   int unsigned status_count [0:7] = '{default: 0};
   int unsigned idle_cycles = 0;
   int unsigned send_gap;
   int unsigned hold_left;
   bit          quiet = 1'b0;
   stream_item_type next_item;
   result_type      wanted;

   // Inputs start from known values, before the first clock edge.
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.func    = FN_BYTE;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      csr_we          = 1'b0;
      csr_index       = REG_START_BYTE;
      csr_wdata       = 8'h00;
   end

   // Gap length for either side. Most gaps are empty or short and a few are
   // long; in quiet stretches there are none at all.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 94)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Drops any partial frame and goes back to hunting. The lock is left alone.
   function automatic void clear_frame();
      parser.phase         = PH_HUNT;
      parser.frame_length  = 4'd0;
      parser.byte_position = 4'd0;
      parser.running_sum   = 8'h00;
      parser.command_byte  = 8'h00;
   endfunction

   // Advances the bench parser by one transaction and returns the response
   // that the receiver should answer it with.
   function automatic result_type parse_byte(input logic fn, input logic [7:0] b);
      result_type r;
      r.status  = ST_IDLE;
      r.command = 8'h00;
      if (fn == FN_RELEASE) begin
         // The reply has gone out: unlock and start afresh, locked or not.
         clear_frame();
         parser.locked = 1'b0;
      end else if (parser.locked) begin
         r.status = ST_LOCKED;
      end else begin
         case (parser.phase)
            PH_HUNT: begin
               if (b == cfg_start) begin
                  parser.running_sum   = b;
                  parser.byte_position = 4'd1;
                  parser.phase         = PH_LEN;
               end
            end
            PH_LEN: begin
               if (b < MIN_LEN || b > FRAME_MAX) begin
                  r.status = ST_BAD_LEN;
                  clear_frame();
               end else begin
                  parser.frame_length  = b[3:0];
                  parser.running_sum   = parser.running_sum + b;
                  parser.byte_position = 4'd2;
                  parser.phase         = PH_ADDR;
               end
            end
            PH_ADDR: begin
               if (b != cfg_address) begin
                  r.status = ST_BAD_ADDR;
                  clear_frame();
               end else begin
                  parser.running_sum   = parser.running_sum + b;
                  parser.byte_position = 4'd3;
                  parser.phase         = PH_DATA;
               end
            end
            default: begin
               // The last byte of the frame is the check byte.
               if ({1'b0, parser.byte_position} + 5'd1 >= {1'b0, parser.frame_length}) begin
                  if (parser.running_sum == b) begin
                     r.status      = ST_OK;
                     r.command     = parser.command_byte;
                     parser.locked = 1'b1;
                  end else begin
                     r.status = ST_BAD_SUM;
                  end
                  clear_frame();
               end else begin
                  if (parser.byte_position == CMD_POS)
                     parser.command_byte = b;
                  parser.running_sum   = parser.running_sum + b;
                  parser.byte_position = parser.byte_position + 4'd1;
               end
            end
         endcase
      end
      return r;
   endfunction

   task automatic push_item(input logic fn, input logic [7:0] b);
      stream_item_type it;
      it.func    = fn;
      it.rx_byte = b;
      byte_stream.push_back(it);
      items_queued++;
   endtask

   // Queues the first cut bytes of a frame of the given length under the
   // current start byte. The check byte is made wrong on request, and the
   // start byte can be planted in the first data byte.
   task automatic push_frame(input int unsigned len, input logic [7:0] addr,
                             input logic [7:0] cmd, input bit bad_sum,
                             input int unsigned cut, input bit start_inside);
      logic [7:0] frame [16];
      logic [7:0] sum;
      sum      = 8'h00;
      frame[0] = cfg_start;
      frame[1] = 8'(len);
      frame[2] = addr;
      for (int i = 3; i < len - 1; i++)
         frame[i] = 8'($urandom_range(0, 255));
      frame[CMD_POS] = cmd;
      if (start_inside)
         frame[3] = cfg_start;
      for (int i = 0; i < len - 1; i++)
         sum += frame[i];
      frame[len - 1] = bad_sum ? sum + 8'($urandom_range(1, 255)) : sum;
      for (int i = 0; i < cut; i++)
         push_item(FN_BYTE, frame[i]);
   endtask

   // Waits until every queued transaction has been answered, then lets the
   // receiver settle before the registers are touched.
   task automatic wait_drained();
      wait (results_seen == items_queued);
      repeat (4) @(posedge clock);
   endtask

   // Writes both registers on consecutive edges and updates the bench copy.
   task automatic write_settings(input logic [7:0] sb, input logic [7:0] addr);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= REG_START_BYTE;
      csr_wdata <= sb;
      @(posedge clock);
      csr_index <= REG_OWN_ADDRESS;
      csr_wdata <= addr;
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg_start   = sb;
      cfg_address = addr;
   endtask

   // One randomly chosen sequence. Most are well-formed frames with random
   // content, each followed by a release so that the receiver does not stay
   // locked; the rest are broken frames, line noise and lone releases.
   task automatic push_random_sequence();
      int unsigned pick;
      int unsigned flen;
      pick = $urandom_range(0, 99);
      flen = $urandom_range(MIN_LEN, FRAME_MAX);
      if (pick < 55) begin
         push_frame(flen, cfg_address, 8'($urandom_range(0, 255)), 1'b0, flen,
                    $urandom_range(0, 9) == 0);
         // Now and then a few bytes arrive while the reply is still going out.
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_item(FN_BYTE, 8'($urandom_range(0, 255)));
         push_item(FN_RELEASE, 8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
         push_frame(flen, cfg_address, 8'($urandom_range(0, 255)), 1'b1, flen,
                    $urandom_range(0, 9) == 0);
      end else if (pick < 73) begin
         push_frame(flen, cfg_address ^ 8'($urandom_range(1, 255)),
                    8'($urandom_range(0, 255)), 1'b0, $urandom_range(3, flen), 1'b0);
      end else if (pick < 81) begin
         push_item(FN_BYTE, cfg_start);
         if ($urandom_range(0, 1) == 0)
            push_item(FN_BYTE, 8'($urandom_range(0, MIN_LEN - 1)));
         else
            push_item(FN_BYTE, 8'($urandom_range(FRAME_MAX + 1, 255)));
      end else if (pick < 89) begin
         repeat ($urandom_range(1, 4)) push_item(FN_BYTE, 8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
         // A frame cut short by a release.
         push_frame(flen, cfg_address, 8'($urandom_range(0, 255)), 1'b0,
                    $urandom_range(1, flen - 1), 1'b0);
         push_item(FN_RELEASE, 8'($urandom_range(0, 255)));
      end else begin
         push_item(FN_RELEASE, 8'($urandom_range(0, 255)));
      end
   endtask

   // Request driver. An accepted transaction is fed through the bench parser
   // at once, so the expected responses stay in the order of acceptance. The
   // next transaction, or a gap, is set up only once the channel is free.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap      <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_replies.push_back(parse_byte(req_bus.func, req_bus.rx_byte));
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap != 0) begin
               req_bus.valid <= 1'b0;
               send_gap      <= send_gap - 1;
            end else if (byte_stream.size() != 0) begin
               next_item        = byte_stream.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.func    <= next_item.func;
               req_bus.rx_byte <= next_item.rx_byte;
               send_gap        <= pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every accepted response is held against the oldest
   // expectation; ready is dropped for random stretches in between.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            status_count[rsp_bus.status]++;
            if (expected_replies.size() == 0) begin
               $display("%0t: response with none expected: status %0d command %02h",
                        $time, rsp_bus.status, rsp_bus.command);
               errors++;
            end else begin
               wanted = expected_replies.pop_front();
               if (rsp_bus.status !== wanted.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, wanted.status, rsp_bus.status);
                  errors++;
               end
               if (rsp_bus.command !== wanted.command) begin
                  $display("%0t: command mismatch: expected %02h, actual %02h",
                           $time, wanted.command, rsp_bus.command);
                  errors++;
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left     <= hold_left - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            hold_left     <= pick_gap();
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, giving up", $time, idle_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cfg_start   = START_BYTE_RST;
      cfg_address = OWN_ADDRESS_RST;
      clear_frame();
      parser.locked = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed opening under the reset values of the registers. A release
      // while idle, a stray byte, the longest good frame with the largest
      // command byte, a byte while locked and a release, lengths just outside
      // either limit, a wrong address, and a frame with a bad check byte that
      // carries the start byte among its data.
      push_item(FN_RELEASE, 8'h00);
      push_item(FN_BYTE, 8'hFF);
      push_frame(FRAME_MAX, cfg_address, 8'hFF, 1'b0, FRAME_MAX, 1'b0);
      push_item(FN_BYTE, 8'h00);
      push_item(FN_RELEASE, 8'hFF);
      push_item(FN_BYTE, cfg_start);
      push_item(FN_BYTE, MIN_LEN - 8'd1);
      push_item(FN_BYTE, cfg_start);
      push_item(FN_BYTE, FRAME_MAX + 8'd1);
      push_frame(MIN_LEN, cfg_address ^ 8'h80, 8'h00, 1'b0, 3, 1'b0);
      push_frame(MIN_LEN, cfg_address, 8'h5A, 1'b1, MIN_LEN, 1'b1);

      for (int phase_no = 0; phase_no < 5; phase_no++) begin
         if (phase_no != 0) begin
            wait_drained();
            // Both extremes, then a random pair, then back to the reset values
            // written explicitly.
            case (phase_no)
               1:       write_settings(8'h00, 8'h00);
               2:       write_settings(8'hFF, 8'hFF);
               3:       write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
               default: write_settings(START_BYTE_RST, OWN_ADDRESS_RST);
            endcase
            // Start every setting with one clean frame and its release.
            push_frame(MIN_LEN, cfg_address, 8'($urandom_range(0, 255)), 1'b0, MIN_LEN, 1'b0);
            push_item(FN_RELEASE, 8'h00);
         end
         while (items_queued < (phase_no + 1) * PHASE_ITEMS) begin
            // Switch between stretches with and without idling from time to time.
            if ($urandom_range(0, 39) == 0)
               quiet = ($urandom_range(0, 3) == 0);
            push_random_sequence();
         end
      end

      wait_drained();
      if (expected_replies.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, expected_replies.size());
         errors++;
      end

      $display("Run covered %0d transactions under five register settings.", results_seen);
      $display("Responses: ok %0d, bad sum %0d, bad address %0d, bad length %0d, locked %0d",
               status_count[ST_OK], status_count[ST_BAD_SUM], status_count[ST_BAD_ADDR],
               status_count[ST_BAD_LEN], status_count[ST_LOCKED]);
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

[sim.f]
hdl/fsr_pkg.sv
hdl/fsr_req_if.sv
hdl/fsr_rsp_if.sv
hdl/fsr_parser.sv
hdl/framed_serial_receiver.sv
tb/tb_framed_serial_receiver.sv
